// ===== rtl/clsdf_pkg.sv =====
// Shared widths, register indexes, sequencer states and helpers of the cable link force unit.
package clsdf_pkg;

	localparam int COORD_W = 32;
	localparam int FORCE_W = 48;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_SPRING  = 2'd0;
	localparam logic [1:0] REG_DAMPING = 2'd1;
	localparam logic [1:0] REG_REST    = 2'd2;

	// Step counts of the sequencer phases.
	// The square root and the unit vector division run on the compare-subtract unit;
	// the stretch division by 20 is one multiply by a reciprocal, taken from the multiplier output register.
	localparam int SQRT_STEPS = 34;
	localparam int NDIV_STEPS = 2;
	localparam int UDIV_STEPS = 31;

	// Low word of ceil(2^36 / 5) = 0x3_3333_3334; its upper part (3) is applied by shift and add.
	localparam logic [31:0] RECIP5_LO = 32'h3333_3334;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL   = 10'b0000000010,
		ST_SQRT  = 10'b0000000100,
		ST_NDIV  = 10'b0000001000,
		ST_MAG   = 10'b0000010000,
		ST_UDIV  = 10'b0000100000,
		ST_UMUL  = 10'b0001000000,
		ST_SUM   = 10'b0010000000,
		ST_EMIT1 = 10'b0100000000,
		ST_EMIT2 = 10'b1000000000
	} state_t;

	// Saturate a 55-bit two's complement sum to the 48-bit force range.
	function automatic logic [47:0] sat48(input logic [54:0] v);
		logic [47:0] r;
		if (v[54:47] == 8'h00 || v[54:47] == 8'hFF) begin
			r = v[47:0];
		end else if (v[54]) begin
			r = {1'b1, 47'd0};
		end else begin
			r = {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/cable_link_spring_damper_force_unit.sv =====
// A link with no spring term skips the unit vector, and the square root is its longest phase.
// With a spring term, each axis of the unit vector adds a 31-step division on the compare-subtract
// unit and a product on the multiplier.
// One item is in work at a time: no new mass is taken until the last one's beats are registered,
// and a first mass marked last goes straight to its end beat state (ST_EMIT2).
// Reset (arst_n low, asynchronous) clears registers, chain state and the output beat.
module cable_link_spring_damper_force_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [clsdf_pkg::ADDR_W-1:0]           paddr,
	input  logic [clsdf_pkg::DATA_W-1:0]           pwdata,
	output logic [clsdf_pkg::DATA_W-1:0]           prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   pos_x,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   pos_y,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   pos_z,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   vel_x,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   vel_y,
	input  logic signed [clsdf_pkg::COORD_W-1:0]   vel_z,
	input  logic                                   is_first,
	input  logic                                   is_last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [clsdf_pkg::FORCE_W-1:0]   force_x,
	output logic signed [clsdf_pkg::FORCE_W-1:0]   force_y,
	output logic signed [clsdf_pkg::FORCE_W-1:0]   force_z,
	output logic                                   zero_link,
	output logic                                   chain_end
);
	import clsdf_pkg::*;

	// Configuration registers.
	logic [31:0] spring_q, damping_q;
	logic [30:0] rest_q;

	// Sequencer.
	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [1:0]  axis_q;

	// Chain state.
	logic [31:0] prev_pos_q [3];
	logic [31:0] prev_vel_q [3];
	logic [47:0] pend_q [3];
	logic        pzl_q, pwf_q, have_prev_q, last_q;

	// Link working registers.
	logic [32:0] d_q [3];
	logic [32:0] rv_q [3];
	logic [67:0] sq_q;
	logic [36:0] rem_q;
	logic [33:0] root_q, lr_q;
	logic [63:0] num_q;
	logic [34:0] den_q;
	logic        zl_q, nneg_q, spring_on_q;
	logic [49:0] m_q;
	logic [47:0] dm_q [3];
	logic [50:0] fm_q [3];
	logic [63:0] facc_q, prod_q;

	// Result holding and output registers.
	logic [47:0] res1_q [3];
	logic [47:0] res2_q [3];
	logic        res1_zl_q, res2_zl_q;
	logic        out_valid_q, out_zl_q, out_end_q;
	logic [47:0] out_f_q [3];

	logic        cfg_wr, in_acc, out_free, new_chain;
	logic [31:0] in_pos [3];
	logic [31:0] in_vel [3];
	logic [31:0] dmag [3];
	logic [31:0] rvmag [3];
	logic [31:0] mul_a, mul_b;
	logic [36:0] cmp_a, cmp_b, cmp_diff;
	logic        cmp_ge;
	logic        sq_exact;
	logic [33:0] lr_nx;
	logic [36:0] v2, vmag;
	logic [35:0] nx_num;
	logic [31:0] nd_lo;
	logic [1:0]  nd_hi;
	logic [33:0] nd_t1, nd_t2;
	logic [3:0]  nd_t3;
	logic [67:0] nq_sum;
	logic [1:0]  udiv_ax;
	logic [63:0] udiv_n;
	logic [66:0] m_sum;
	logic [63:0] dm_sum;
	logic [95:0] fm_sum;
	logic [54:0] f1 [3];
	logic [54:0] p2 [3];

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign new_chain = is_first || !have_prev_q;

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;
	assign in_vel[0] = vel_x;
	assign in_vel[1] = vel_y;
	assign in_vel[2] = vel_z;

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_SPRING:  prdata = spring_q;
			REG_DAMPING: prdata = damping_q;
			REG_REST:    prdata = {1'b0, rest_q};
			default:     prdata = '0;
		endcase
	end

	// Magnitudes of the link difference and relative velocity.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [32:0] dn, rn;
			dn = 33'd0 - d_q[j];
			rn = 33'd0 - rv_q[j];
			dmag[j]  = d_q[j][32] ? dn[31:0] : d_q[j][31:0];
			rvmag[j] = rv_q[j][32] ? rn[31:0] : rv_q[j][31:0];
		end
	end

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL: begin
				case (cnt_q)
					6'd0: begin mul_a = dmag[0];   mul_b = dmag[0];  end
					6'd1: begin mul_a = dmag[1];   mul_b = dmag[1];  end
					6'd2: begin mul_a = dmag[2];   mul_b = dmag[2];  end
					6'd3: begin mul_a = damping_q; mul_b = rvmag[0]; end
					6'd4: begin mul_a = damping_q; mul_b = rvmag[1]; end
					6'd5: begin mul_a = damping_q; mul_b = rvmag[2]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_NDIV: begin
				mul_a = nd_lo;
				mul_b = RECIP5_LO;
			end
			ST_MAG: begin
				mul_a = spring_q;
				mul_b = num_q[31:0];
			end
			ST_UMUL: begin
				mul_a = (cnt_q == 6'd0) ? m_q[31:0] : {14'd0, m_q[49:32]};
				mul_b = {1'b0, num_q[30:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared compare-subtract unit: root digits in SQRT, quotient bits in the unit vector division.
	always_comb begin
		if (state_q == ST_SQRT) begin
			cmp_a = {rem_q[34:0], sq_q[67:66]};
			cmp_b = {1'b0, root_q, 2'b01};
		end else begin
			cmp_a = {rem_q[35:0], num_q[63]};
			cmp_b = {2'b00, den_q};
		end
		cmp_ge   = (cmp_a >= cmp_b);
		cmp_diff = cmp_a - cmp_b;
	end

	// Rounded length and stretch numerator once the root is done.
	always_comb begin
		sq_exact = (rem_q == '0);
		lr_nx    = (rem_q <= {3'd0, root_q}) ? root_q : root_q + 34'd1;
		v2       = {2'b00, root_q, 1'b0} - {5'd0, rest_q, 1'b0} + {36'd0, !sq_exact};
		vmag     = v2[36] ? 37'd0 - v2 : v2;
		nx_num   = vmag[35:0] + 36'd10;
	end

	// Stretch count: x / 20 taken as ((x >> 2) * ceil(2^36 / 5)) >> 36, exact for x >> 2 below 2^34.
	// The low word of the reciprocal goes through the multiplier, the rest is shift and add.
	always_comb begin
		nd_lo  = num_q[33:2];
		nd_hi  = num_q[35:34];
		nd_t1  = {1'b0, nd_lo, 1'b0} + {2'd0, nd_lo};
		nd_t2  = ({2'd0, RECIP5_LO} & {34{nd_hi[0]}}) + ({1'b0, RECIP5_LO, 1'b0} & {34{nd_hi[1]}});
		nd_t3  = {2'd0, nd_hi} + {1'b0, nd_hi, 1'b0};
		nq_sum = {4'd0, prod_q} + {2'd0, nd_t1, 32'd0} + {2'd0, nd_t2, 32'd0} + {nd_t3, 64'd0};
	end

	// Division setup for the unit vector of one axis.
	always_comb begin
		udiv_ax = (state_q == ST_UMUL) ? axis_q + 2'd1 : 2'd0;
		case (udiv_ax)
			2'd0:    udiv_n = {1'b0, dmag[0], 31'd0} + {30'd0, lr_q};
			2'd1:    udiv_n = {1'b0, dmag[1], 31'd0} + {30'd0, lr_q};
			2'd2:    udiv_n = {1'b0, dmag[2], 31'd0} + {30'd0, lr_q};
			default: udiv_n = '0;
		endcase
	end

	// Rounding of the multiplier products.
	always_comb begin
		m_sum  = {prod_q, 3'd0} + {2'd0, prod_q, 1'b0} + {51'd0, 1'b1, 15'd0};
		dm_sum = prod_q + {48'd0, 1'b1, 15'd0};
		fm_sum = {32'd0, facc_q} + {prod_q, 32'd0} + {66'd0, 1'b1, 29'd0};
	end

	// Force sums of both masses of the link.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic [54:0] fext, fsv, dext, dsv, pext;
			fext = {4'd0, fm_q[j]};
			dext = {7'd0, dm_q[j]};
			if (!spring_on_q) begin
				fsv = '0;
			end else if (nneg_q ^ d_q[j][32]) begin
				fsv = 55'd0 - fext;
			end else begin
				fsv = fext;
			end
			dsv  = rv_q[j][32] ? 55'd0 - dext : dext;
			pext = {{7{pend_q[j][47]}}, pend_q[j]};
			f1[j] = pext + (pwf_q ? 55'd0 - fsv : fsv) + dsv;
			p2[j] = (last_q ? fsv : 55'd0 - fsv) - dsv;
		end
	end

	// Multiplier with its output register.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_q  <= '0;
			damping_q <= '0;
			rest_q    <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SPRING:  spring_q  <= pwdata;
				REG_DAMPING: damping_q <= pwdata;
				REG_REST:    rest_q    <= pwdata[30:0];
				default:     ;
			endcase
		end
	end

	// Sequencer and chain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= '0;
			pzl_q       <= 1'b0;
			pwf_q       <= 1'b0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			sq_q        <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			lr_q        <= '0;
			num_q       <= '0;
			den_q       <= '0;
			zl_q        <= 1'b0;
			nneg_q      <= 1'b0;
			spring_on_q <= 1'b0;
			m_q         <= '0;
			facc_q      <= '0;
			res1_zl_q   <= 1'b0;
			res2_zl_q   <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				prev_pos_q[j] <= '0;
				prev_vel_q[j] <= '0;
				pend_q[j]     <= '0;
				d_q[j]        <= '0;
				rv_q[j]       <= '0;
				dm_q[j]       <= '0;
				fm_q[j]       <= '0;
				res1_q[j]     <= '0;
				res2_q[j]     <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						for (int j = 0; j < 3; j++) begin
							d_q[j]  <= {in_pos[j][31], in_pos[j]} - {prev_pos_q[j][31], prev_pos_q[j]};
							rv_q[j] <= {in_vel[j][31], in_vel[j]} - {prev_vel_q[j][31], prev_vel_q[j]};
							prev_pos_q[j] <= in_pos[j];
							prev_vel_q[j] <= in_vel[j];
						end
						last_q <= is_last;
						cnt_q  <= '0;
						sq_q   <= '0;
						if (new_chain) begin
							for (int j = 0; j < 3; j++) begin
								pend_q[j] <= '0;
								res2_q[j] <= '0;
							end
							pzl_q       <= 1'b0;
							pwf_q       <= 1'b1;
							have_prev_q <= !is_last;
							res2_zl_q   <= 1'b0;
							state_q     <= is_last ? ST_EMIT2 : ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					case (cnt_q)
						6'd1, 6'd2, 6'd3: sq_q <= sq_q + {4'd0, prod_q};
						6'd4: dm_q[0] <= dm_sum[63:16];
						6'd5: dm_q[1] <= dm_sum[63:16];
						6'd6: dm_q[2] <= dm_sum[63:16];
						default: ;
					endcase
					if (cnt_q == 6'd6) begin
						zl_q    <= (sq_q == '0);
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == 6'(SQRT_STEPS)) begin
						lr_q    <= lr_nx;
						nneg_q  <= v2[36];
						num_q   <= {28'd0, nx_num};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_NDIV;
					end else begin
						rem_q  <= cmp_ge ? cmp_diff : cmp_a;
						root_q <= {root_q[32:0], cmp_ge};
						sq_q   <= {sq_q[65:0], 2'b00};
						cnt_q  <= cnt_q + 6'd1;
					end
				end
				ST_NDIV: begin
					if (cnt_q == 6'(NDIV_STEPS - 1)) begin
						num_q   <= {32'd0, nq_sum[67:36]};
						cnt_q   <= '0;
						state_q <= ST_MAG;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_MAG: begin
					if (cnt_q == 6'd0) begin
						cnt_q <= 6'd1;
					end else begin
						m_q         <= m_sum[65:16];
						spring_on_q <= !zl_q && (num_q[35:0] != '0);
						cnt_q       <= '0;
						axis_q      <= '0;
						if (!zl_q && (num_q[35:0] != '0)) begin
							rem_q   <= {4'd0, udiv_n[63:31]};
							num_q   <= {udiv_n[30:0], 33'd0};
							den_q   <= {lr_q, 1'b0};
							state_q <= ST_UDIV;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_UDIV: begin
					rem_q <= cmp_ge ? cmp_diff : cmp_a;
					num_q <= {num_q[62:0], cmp_ge};
					if (cnt_q == 6'(UDIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_UMUL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_UMUL: begin
					case (cnt_q)
						6'd0: cnt_q <= 6'd1;
						6'd1: begin
							facc_q <= prod_q;
							cnt_q  <= 6'd2;
						end
						default: begin
							fm_q[axis_q] <= fm_sum[80:30];
							cnt_q        <= '0;
							if (axis_q == 2'd2) begin
								state_q <= ST_SUM;
							end else begin
								axis_q  <= udiv_ax;
								rem_q   <= {4'd0, udiv_n[63:31]};
								num_q   <= {udiv_n[30:0], 33'd0};
								state_q <= ST_UDIV;
							end
						end
					endcase
				end
				ST_SUM: begin
					for (int j = 0; j < 3; j++) begin
						res1_q[j] <= sat48(f1[j]);
						res2_q[j] <= sat48(p2[j]);
						pend_q[j] <= last_q ? 48'd0 : sat48(p2[j]);
					end
					res1_zl_q   <= pzl_q | zl_q;
					res2_zl_q   <= zl_q;
					pzl_q       <= last_q ? 1'b0 : zl_q;
					pwf_q       <= 1'b0;
					have_prev_q <= !last_q;
					state_q     <= ST_EMIT1;
				end
				ST_EMIT1: begin
					if (out_free) begin
						state_q <= last_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_EMIT1 || state_q == ST_EMIT2)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT1) begin
			out_f_q   <= res1_q;
			out_zl_q  <= res1_zl_q;
			out_end_q <= 1'b0;
		end else if (out_free && state_q == ST_EMIT2) begin
			out_f_q   <= res2_q;
			out_zl_q  <= res2_zl_q;
			out_end_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign force_x   = out_f_q[0];
	assign force_y   = out_f_q[1];
	assign force_z   = out_f_q[2];
	assign zero_link = out_zl_q;
	assign chain_end = out_end_q;

	// A single-mass chain goes straight to its end beat.
	a_single_mass: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && new_chain && is_last |=> state_q == ST_EMIT2)
		else $error("single-mass chain did not go to its end beat");

	// A new output beat only comes from an emit state.
	a_beat_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT1 || $past(state_q) == ST_EMIT2)
		else $error("output beat raised outside an emit state");

	// The divider remainder stays below its divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UDIV |-> rem_q < {2'b00, den_q})
		else $error("divider remainder not below divisor");

	// Unit vector products are only formed for a link with a spring term.
	a_umul_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UMUL |-> spring_on_q && !zl_q)
		else $error("unit vector product on a link without spring term");

endmodule

// ===== sim/cable_link_spring_damper_force_unit_test.sv =====
// Self-checking testbench of the cable link spring-damper force unit.
`timescale 1ns / 1ps

module cable_link_spring_damper_force_unit_test;
	import clsdf_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam longint FORCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint FORCE_MIN = -64'sh0000_8000_0000_0000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic signed [31:0] px, py, pz, vx, vy, vz;
		logic first, last;
	} mass_t;

	typedef struct packed {
		logic [47:0] fx, fy, fz;
		logic zl, ce;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
	logic is_first = 1'b0, is_last = 1'b0;
	logic out_valid, out_stall = 1'b0;
	logic signed [47:0] force_x, force_y, force_z;
	logic zero_link, chain_end;

	cable_link_spring_damper_force_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.is_first(is_first), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.zero_link(zero_link), .chain_end(chain_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of registers and chain state.
	logic [31:0] k_spring = '0, c_damp = '0;
	logic [30:0] rest_len = '0;
	longint prev_pos[3], prev_vel[3], pend_force[3];
	bit pend_zl, prev_first, have_prev;

	mass_t mass_q[$];
	force_t force_q[$];
	int send_idle = 0, recv_idle = 0;
	int errors = 0;
	bit beat_taken = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// Rounded a*b / 2^sh.
	function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1));
		return p[sh +: 64];
	endfunction

	function automatic longint clip48(longint v);
		if (v > FORCE_MAX) return FORCE_MAX;
		if (v < FORCE_MIN) return FORCE_MIN;
		return v;
	endfunction

	function automatic force_t make_force(longint f[3], bit zl, bit ce);
		force_t e;
		e.fx = 48'(clip48(f[0]));
		e.fy = 48'(clip48(f[1]));
		e.fz = 48'(clip48(f[2]));
		e.zl = zl;
		e.ce = ce;
		return e;
	endfunction

	// Work out the forces that one accepted mass releases.
	task automatic predict_forces(mass_t m);
		longint p[3], v[3], d[3], fs[3], ds[3], f[3];
		longint v2, n, rv;
		logic [127:0] s, c2;
		logic [63:0] r, c, lr, dm, mm, u, fm, am;
		bit zl, exact;
		p[0] = m.px; p[1] = m.py; p[2] = m.pz;
		v[0] = m.vx; v[1] = m.vy; v[2] = m.vz;
		if (m.first || !have_prev) begin
			for (int j = 0; j < 3; j++) begin
				prev_pos[j] = p[j]; prev_vel[j] = v[j]; pend_force[j] = 0; f[j] = 0;
			end
			pend_zl = 0; prev_first = 1; have_prev = 1;
			if (m.last) begin
				have_prev = 0;
				force_q.push_back(make_force(f, 1'b0, 1'b1));
			end
			return;
		end
		// Squared link length and its integer square root.
		s = '0;
		for (int j = 0; j < 3; j++) begin
			d[j] = p[j] - prev_pos[j];
			am = d[j] < 0 ? -d[j] : d[j];
			s = s + {64'd0, am} * {64'd0, am};
		end
		zl = (s == 0);
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			c2 = {64'd0, c} * {64'd0, c};
			if (c2 <= s) r = c;
		end
		c2 = {64'd0, r} * {64'd0, r};
		exact = (c2 == s);
		lr = (s <= c2 + {64'd0, r}) ? r : r + 1;
		// Stretch in 10 um steps, ties away from zero.
		v2 = 2 * (longint'(r) - longint'(rest_len)) + (exact ? 0 : 1);
		n = ((v2 < 0 ? -v2 : v2) + 10) / 20;
		if (v2 < 0) n = -n;
		for (int j = 0; j < 3; j++) begin
			rv = v[j] - prev_vel[j];
			dm = mul_round({32'd0, c_damp}, rv < 0 ? -rv : rv, 16);
			ds[j] = rv < 0 ? -longint'(dm) : longint'(dm);
			fs[j] = 0;
		end
		if (!zl && n != 0) begin
			mm = mul_round({32'd0, k_spring} * 64'(n < 0 ? -n : n), 64'd10, 16);
			for (int j = 0; j < 3; j++) begin
				am = d[j] < 0 ? -d[j] : d[j];
				u = ((am << 31) + lr) / (2 * lr);
				fm = mul_round(mm, u, 30);
				fs[j] = ((n < 0) != (d[j] < 0)) ? -longint'(fm) : longint'(fm);
			end
		end
		for (int j = 0; j < 3; j++)
			f[j] = pend_force[j] + (prev_first ? -fs[j] : fs[j]) + ds[j];
		force_q.push_back(make_force(f, pend_zl | zl, 1'b0));
		for (int j = 0; j < 3; j++) begin
			pend_force[j] = clip48((m.last ? fs[j] : -fs[j]) - ds[j]);
			prev_pos[j] = p[j]; prev_vel[j] = v[j];
		end
		pend_zl = zl; prev_first = 0;
		if (m.last) begin
			force_q.push_back(make_force(pend_force, zl, 1'b1));
			for (int j = 0; j < 3; j++) pend_force[j] = 0;
			pend_zl = 0; have_prev = 0;
		end
	endtask

	// Input side: accept at the rising edge, offer the next beat at the falling edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_forces({pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, is_first, is_last});
			beat_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		mass_t m;
		if (!in_valid || beat_taken) begin
			beat_taken = 1'b0;
			if (mass_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				m = mass_q.pop_front();
				{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, is_first, is_last} <= m;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side stall, with an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Compare each output beat with the oldest expected force.
	always @(posedge clk) begin
		force_t e;
		if (out_valid && !out_stall) begin
			if (force_q.size() == 0) begin
				errors = errors + 1;
				if (errors <= 10) $display("unexpected output beat %h %h %h", force_x, force_y, force_z);
			end else begin
				e = force_q.pop_front();
				if (e != {force_x, force_y, force_z, zero_link, chain_end}) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("mismatch: expected %h %h %h zl=%b end=%b, got %h %h %h zl=%b end=%b",
							e.fx, e.fy, e.fz, e.zl, e.ce,
							force_x, force_y, force_z, zero_link, chain_end);
				end
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_SPRING: k_spring = val;
			REG_DAMPING: c_damp = val;
			REG_REST: rest_len = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] k, logic [31:0] c, logic [31:0] rl);
		reg_write(REG_SPRING, k);
		reg_write(REG_DAMPING, c);
		reg_write(REG_REST, rl);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (mass_q.size() != 0 || in_valid || force_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] any_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] step_coord(logic signed [31:0] base, int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic mass_t next_mass(mass_t prev, bit first, bit last, int span);
		mass_t m;
		int mode;
		mode = $urandom_range(0, 9);
		if (first || mode >= 8) begin
			m.px = any_coord(); m.py = any_coord(); m.pz = any_coord();
		end else if (mode == 7) begin
			m.px = prev.px; m.py = prev.py; m.pz = prev.pz;
		end else begin
			m.px = step_coord(prev.px, span);
			m.py = step_coord(prev.py, span);
			m.pz = step_coord(prev.pz, span);
		end
		if ($urandom_range(0, 2) == 0) begin
			m.vx = $urandom; m.vy = $urandom; m.vz = $urandom;
		end else begin
			m.vx = step_coord(0, 50000); m.vy = step_coord(0, 50000); m.vz = step_coord(0, 50000);
		end
		m.first = first;
		m.last = last;
		return m;
	endfunction

	// Mostly well-formed chains, some noise and broken chains.
	task automatic queue_chains(int count, int span);
		mass_t m;
		int len, made;
		made = 0;
		m = '0;
		while (made < count) begin
			if ($urandom_range(0, 9) == 0) begin
				m = next_mass(m, 1'b0, 1'b0, span);
				m.first = 1'($urandom_range(0, 1));
				m.last = 1'($urandom_range(0, 1));
				mass_q.push_back(m);
				made++;
			end else begin
				len = $urandom_range(1, 7);
				for (int k = 0; k < len; k++) begin
					m = next_mass(m, k == 0, k == len - 1, span);
					mass_q.push_back(m);
					made++;
				end
			end
		end
	endtask

	function automatic mass_t at(int x, int y, int z, int v, bit first, bit last);
		mass_t m;
		m.px = x; m.py = y; m.pz = z;
		m.vx = v; m.vy = -v; m.vz = v;
		m.first = first; m.last = last;
		return m;
	endfunction

	initial begin
		for (int j = 0; j < 3; j++) begin
			prev_pos[j] = 0; prev_vel[j] = 0; pend_force[j] = 0;
		end
		pend_zl = 0; prev_first = 0; have_prev = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: edge cases under an ordinary setting.
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		set_regs(32'h0001_0000, 32'h0000_8000, 32'd1000);
		mass_q.push_back(at(0, 0, 0, 5, 1, 1));            // single-mass chain
		mass_q.push_back(at(100, 0, 0, 7, 0, 0));          // no chain start held
		mass_q.push_back(at(100, 0, 0, 9, 0, 0));          // zero-length link
		mass_q.push_back(at(1300, 0, 0, -4, 0, 0));
		mass_q.push_back(at(5, 5, 5, 1, 1, 0));            // new start mid-chain
		mass_q.push_back(at(5, 5, 1020, 3, 0, 1));
		mass_q.push_back(at(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 1, 0));
		mass_q.push_back(at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 0, 0));
		mass_q.push_back(at(32'sh8000_0000, 0, 32'sh7FFF_FFFF, -1, 0, 1));
		mass_q.push_back(at(0, 0, 0, 0, 1, 0));
		mass_q.push_back(at(0, 0, 1015, 0, 0, 0));         // stretch tie
		mass_q.push_back(at(0, 0, 1020, 0, 0, 0));         // exact length tie
		mass_q.push_back(at(0, 0, 0, 0, 0, 1));
		mass_q.push_back(at(-1, -1, -1, -1, 0, 1));
		drain();

		// Extremes of every register, sender mostly busy, receiver slow.
		send_idle = 7; recv_idle = 68;
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_chains(380, 3000);
		drain();

		// All registers zero, sender slow, receiver fast.
		send_idle = 68; recv_idle = 7;
		set_regs(32'd0, 32'd0, 32'd0);
		queue_chains(380, 3000);
		drain();

		// Random setting, no idling.
		send_idle = 0; recv_idle = 0;
		set_regs($urandom, $urandom, $urandom_range(0, 5000));
		queue_chains(380, 6000);
		drain();

		// Realistic setting, no idling, with a long receiver hold-off.
		set_regs(32'h0064_0000, 32'h0000_2000, $urandom_range(500, 2000));
		queue_chains(390, 2500);
		repeat (20) @(posedge clk);
		hold_req = 1'b1;
		drain();

		if (errors == 0) begin
			$display("cable_link_spring_damper_force_unit_test: done, clean");
		end else begin
			$display("cable_link_spring_damper_force_unit_test: done, errors");
		end
		$finish;
	end

	initial begin
		#6000000;
		$display("cable_link_spring_damper_force_unit_test: done, errors");
		$finish;
	end

endmodule
